>>> rtl/tpd_pkg.sv
// Shared types and constants for the triac phase-angle dimmer.
package tpd_pkg;

  // Register map of the configuration port.
  typedef enum logic [1:0] {
    REG_BRIGHTNESS  = 2'd0,
    REG_MAX_DELAY   = 2'd1,
    REG_MIN_DELAY   = 2'd2,
    REG_PULSE_TICKS = 2'd3
  } cfg_reg_t;

  // Controller phase, also shown on the phase output.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_PULSE = 2'd2
  } phase_t;

  localparam int BRIGHT_W = 7;
  localparam int TIME_W   = 16;
  localparam int SCALED_W = BRIGHT_W + TIME_W;

  localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 7'd100;

  // floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for every x below 2**23.
  localparam int                  RECIP_W     = 24;
  localparam int                  RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0]  RECIP       = 24'd10737419;

  localparam logic [TIME_W-1:0] MAX_DELAY_RST   = 16'd9500;
  localparam logic [TIME_W-1:0] MIN_DELAY_RST   = 16'd500;
  localparam logic [TIME_W-1:0] PULSE_TICKS_RST = 16'd100;

  // Timing settings handed from the register block to the controller.
  typedef struct packed {
    logic              bright_zero;
    logic [TIME_W-1:0] fire_delay;
    logic [TIME_W-1:0] pulse_ticks;
  } timing_t;

endpackage

>>> rtl/triac_phase_angle_dimmer_core.sv
// Top level of the leading-edge triac phase-angle dimmer.
// A word passes both input stages, and its result shows from the result register.
// Throughput: one word per cycle unless result_stall backs up the three registers.
// A configuration write reaches the firing delay through two multiplier stages,
// which the two pipeline registers in front of the timer cover.
// Reset (synchronous, active high) empties the pipeline, idles the timer and clears
// its gate state (not gate_drive) and loads defaults; no word is taken while held.
module triac_phase_angle_dimmer_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        zero_cross,
  input  logic        tick,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        gate_drive,
  output logic [1:0]  phase
);
  import tpd_pkg::*;

  // Settings seen by the timer: brightness-zero flag, firing delay in ticks
  // (maximum delay less the brightness share of the span) and pulse length.
  timing_t timing;

  // The register block works out the firing delay continuously, so the timer
  // only ever has to pick up a ready value when a zero crossing arrives.
  tpd_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .timing       (timing)
  );

  // The controller holds two input stages, the one-shot timer and the result
  // register. Each stage moves on when the one after it is empty or moving,
  // so a new word is taken while a finished result still waits to be read.
  tpd_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .timing       (timing),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .zero_cross   (zero_cross),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .gate_drive   (gate_drive),
    .phase        (phase)
  );

endmodule

>>> rtl/tpd_cfg.sv
// Configuration registers and the pipelined firing-delay calculation.
module tpd_cfg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  output tpd_pkg::timing_t       timing
);
  import tpd_pkg::*;

  logic [BRIGHT_W-1:0]            brightness;
  logic [TIME_W-1:0]              max_delay;
  logic [TIME_W-1:0]              min_delay;
  logic [TIME_W-1:0]              pulse_ticks;
  logic [BRIGHT_W-1:0]            bright_sat;
  logic [TIME_W-1:0]              span;
  logic [SCALED_W-1:0]            scaled;
  logic [SCALED_W+RECIP_W-1:0]    recip_prod;
  logic [TIME_W-1:0]              quot;

  assign bright_sat = (cfg_data[BRIGHT_W-1:0] > BRIGHT_FULL) ? BRIGHT_FULL
                                                             : cfg_data[BRIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness  <= '0;
      max_delay   <= MAX_DELAY_RST;
      min_delay   <= MIN_DELAY_RST;
      pulse_ticks <= PULSE_TICKS_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BRIGHTNESS:  brightness  <= bright_sat;
        REG_MAX_DELAY:   max_delay   <= cfg_data;
        REG_MIN_DELAY:   min_delay   <= cfg_data;
        REG_PULSE_TICKS: pulse_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // A minimum above the maximum gives an empty span.
  assign span       = (max_delay >= min_delay) ? (max_delay - min_delay) : '0;
  assign recip_prod = (SCALED_W+RECIP_W)'(scaled) * (SCALED_W+RECIP_W)'(RECIP);

  // Two stages: brightness times span, then the division by one hundred.
  // Both clear on reset, which matches the reset brightness of zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      scaled <= '0;
      quot   <= '0;
    end else begin
      scaled <= SCALED_W'(brightness) * SCALED_W'(span);
      quot   <= recip_prod[RECIP_SHIFT +: TIME_W];
    end
  end

  assign timing.bright_zero = (brightness == '0);
  assign timing.fire_delay  = max_delay - quot;
  assign timing.pulse_ticks = pulse_ticks;

endmodule

>>> rtl/tpd_ctrl.sv
// Word pipeline, one-shot timer state machine and result register.
module tpd_ctrl #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tpd_pkg::timing_t       timing,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   zero_cross,
  input  logic                   tick,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   gate_drive,
  output logic [1:0]             phase
);
  import tpd_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'({COUNT_WIDTH{1'b1}});

  logic                   valid1, zc1, tk1;
  logic                   valid2, zc2, tk2;
  logic                   out_free, s2_free, adv2, accept;

  phase_t                 phase_reg, phase_next;
  logic [COUNT_WIDTH-1:0] countdown, countdown_next;
  logic                   timer_running, timer_running_next;
  logic                   gate_reg, gate_next;

  // Loads wider than the counter saturate at its maximum.
  function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [TIME_W-1:0] v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    return (ext > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0] : ext[COUNT_WIDTH-1:0];
  endfunction

  assign out_free   = !result_valid || !result_stall;
  assign s2_free    = !valid2 || out_free;
  assign adv2       = valid2 && out_free;
  assign item_stall = rst || (valid1 && !s2_free);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1       <= 1'b0;
      valid2       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        valid1 <= 1'b1;
      end else if (valid1 && s2_free) begin
        valid1 <= 1'b0;
      end
      if (s2_free) begin
        valid2 <= valid1;
      end
      if (out_free) begin
        result_valid <= valid2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      zc1 <= zero_cross;
      tk1 <= tick;
    end
    if (s2_free) begin
      zc2 <= zc1;
      tk2 <= tk1;
    end
    if (adv2) begin
      gate_drive <= gate_next;
      phase      <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      countdown     <= '0;
      timer_running <= 1'b0;
      gate_reg      <= 1'b0;
    end else if (adv2) begin
      phase_reg     <= phase_next;
      countdown     <= countdown_next;
      timer_running <= timer_running_next;
      gate_reg      <= gate_next;
    end
  end

  always_comb begin
    phase_next         = phase_reg;
    countdown_next     = countdown;
    timer_running_next = timer_running;
    gate_next          = gate_reg;
    if (zc2) begin
      if (timing.bright_zero) begin
        phase_next         = PH_IDLE;
        countdown_next     = '0;
        timer_running_next = 1'b0;
        gate_next          = 1'b0;
      end else begin
        // The gate is left as it is, so a crossing during a pulse keeps it high.
        phase_next         = PH_WAIT;
        countdown_next     = sat_count(timing.fire_delay);
        timer_running_next = 1'b1;
      end
    end else if (tk2 && timer_running) begin
      if (countdown <= COUNT_WIDTH'(1)) begin
        unique case (phase_reg)
          PH_WAIT: begin
            phase_next     = PH_PULSE;
            countdown_next = sat_count(timing.pulse_ticks);
            gate_next      = 1'b1;
          end
          PH_PULSE: begin
            phase_next         = PH_IDLE;
            countdown_next     = '0;
            timer_running_next = 1'b0;
            gate_next          = 1'b0;
          end
          default: begin
            countdown_next     = '0;
            timer_running_next = 1'b0;
          end
        endcase
      end else begin
        countdown_next = countdown - COUNT_WIDTH'(1);
      end
    end
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the leading-edge triac phase-angle dimmer core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpd_pkg::*;

  // The run is cut off here.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 105;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One result word: the gate level and the controller phase after the tick.
  typedef struct {
    logic   gate;
    phase_t ph;
  } dimmer_out_t;

  // One row of the directed plan. A row is a register write or an input word.
  // Where known is set, the expected result is typed into the row.
  typedef struct {
    bit          is_cfg;
    cfg_reg_t    idx;
    logic [15:0] data;
    logic        zc;
    logic        tk;
    bit          known;
    logic        gate;
    phase_t      ph;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        zero_cross = 1'b0;
  logic        tick = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        gate_drive;
  logic [1:0]  phase;

  triac_phase_angle_dimmer_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .zero_cross   (zero_cross),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .gate_drive   (gate_drive),
    .phase        (phase)
  );

  always #10 clk = ~clk;

  // The testbench's own copy of the settings, as the block should hold them.
  logic [6:0]  set_bright = 7'd0;
  logic [15:0] set_max    = MAX_DELAY_RST;
  logic [15:0] set_min    = MIN_DELAY_RST;
  logic [15:0] set_pulse  = PULSE_TICKS_RST;

  // The testbench's own copy of the timer state.
  phase_t      dim_phase   = PH_IDLE;
  logic [15:0] dim_count   = 16'd0;
  logic        dim_running = 1'b0;
  logic        dim_gate    = 1'b0;

  dimmer_out_t gate_expect_q [$];

  idle_mode_t  idle_mode     = IDLE_NONE;
  bit          hold_off_req  = 1'b0;
  int          hold_left     = 0;
  int          cycle_count   = 0;
  int          mismatches    = 0;
  int          words_sent    = 0;
  int          words_checked = 0;
  int          crossings     = 0;
  int          firings       = 0;
  int          cfg_writes    = 0;
  bit          in_writes     = 1'b0;

  function automatic plan_row_t cfg_row(input cfg_reg_t idx, input logic [15:0] data);
    plan_row_t r;
    r = '{1'b1, idx, data, 1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE};
    return r;
  endfunction

  function automatic plan_row_t word_row(input logic zc, input logic tk);
    plan_row_t r;
    r = '{1'b0, REG_BRIGHTNESS, 16'd0, zc, tk, 1'b0, 1'b0, PH_IDLE};
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic zc, input logic tk,
                                          input logic gate, input phase_t ph);
    plan_row_t r;
    r = '{1'b0, REG_BRIGHTNESS, 16'd0, zc, tk, 1'b1, gate, ph};
    return r;
  endfunction

  // Directed plan: reset state, the crossing with the lamp off, a crossing in the
  // middle of a pulse, zero-length delay and pulse, minimum above maximum,
  // brightness saturation and the widest delay.
  plan_row_t plan [0:35] = '{
    known_row(1'b0, 1'b0, 1'b0, PH_IDLE),
    known_row(1'b0, 1'b1, 1'b0, PH_IDLE),
    known_row(1'b1, 1'b1, 1'b0, PH_IDLE),
    cfg_row(REG_BRIGHTNESS, 16'h007F),
    cfg_row(REG_MAX_DELAY, 16'd3),
    cfg_row(REG_MIN_DELAY, 16'd1),
    cfg_row(REG_PULSE_TICKS, 16'd2),
    word_row(1'b1, 1'b1),
    word_row(1'b0, 1'b1),
    word_row(1'b0, 1'b0),
    word_row(1'b0, 1'b1),
    word_row(1'b1, 1'b0),
    word_row(1'b0, 1'b1),
    word_row(1'b0, 1'b1),
    word_row(1'b0, 1'b1),
    word_row(1'b1, 1'b0),
    word_row(1'b0, 1'b1),
    cfg_row(REG_BRIGHTNESS, 16'd0),
    known_row(1'b1, 1'b0, 1'b0, PH_IDLE),
    cfg_row(REG_MAX_DELAY, 16'd0),
    cfg_row(REG_MIN_DELAY, 16'hFFFF),
    cfg_row(REG_BRIGHTNESS, 16'd1),
    cfg_row(REG_PULSE_TICKS, 16'd0),
    word_row(1'b1, 1'b0),
    word_row(1'b0, 1'b1),
    word_row(1'b0, 1'b1),
    cfg_row(REG_MAX_DELAY, 16'hFFFF),
    cfg_row(REG_MIN_DELAY, 16'd0),
    cfg_row(REG_BRIGHTNESS, 16'd50),
    word_row(1'b1, 1'b1),
    word_row(1'b0, 1'b1),
    cfg_row(REG_MIN_DELAY, 16'hFFFF),
    cfg_row(REG_BRIGHTNESS, 16'd100),
    word_row(1'b1, 1'b0),
    word_row(1'b0, 1'b1),
    word_row(1'b0, 1'b1)
  };

  task automatic note_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Firing delay from the settings in force at the crossing. A minimum above
  // the maximum gives an empty span, so the delay is then the maximum itself.
  function automatic logic [15:0] firing_delay();
    int unsigned span;
    int unsigned cut;
    span = (set_max >= set_min) ? 32'(set_max) - 32'(set_min) : 0;
    cut  = (32'(set_bright) * span) / 100;
    return 16'(32'(set_max) - cut);
  endfunction

  // Advances the timer by one input word and returns the outputs after it.
  function automatic dimmer_out_t dimmer_step(input logic zc, input logic tk);
    dimmer_out_t o;
    if (zc) begin
      if (set_bright == 7'd0) begin
        dim_running = 1'b0;
        dim_count   = 16'd0;
        dim_gate    = 1'b0;
        dim_phase   = PH_IDLE;
      end else begin
        // The counter is as wide as the delay fields, so no saturation is needed.
        dim_count   = firing_delay();
        dim_running = 1'b1;
        dim_phase   = PH_WAIT;
      end
    end else if (tk && dim_running) begin
      if (dim_count <= 16'd1) begin
        case (dim_phase)
          PH_WAIT: begin
            dim_gate  = 1'b1;
            dim_count = set_pulse;
            dim_phase = PH_PULSE;
          end
          PH_PULSE: begin
            dim_gate    = 1'b0;
            dim_count   = 16'd0;
            dim_running = 1'b0;
            dim_phase   = PH_IDLE;
          end
          default: begin
            dim_count   = 16'd0;
            dim_running = 1'b0;
          end
        endcase
      end else begin
        dim_count = dim_count - 16'd1;
      end
    end
    o.gate = dim_gate;
    o.ph   = dim_phase;
    return o;
  endfunction

  function automatic int gap_pct(input bit sender_side);
    case (idle_mode)
      IDLE_SENDER:   return sender_side ? 63 : 0;
      IDLE_RECEIVER: return sender_side ? 0 : 63;
      IDLE_BOTH:     return 12;
      default:       return 0;
    endcase
  endfunction

  // Register write; the enable is left high so that back-to-back writes need
  // only one assignment per clock step. close_writes lowers it.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    case (idx)
      REG_BRIGHTNESS:  set_bright = (data[6:0] > BRIGHT_FULL) ? BRIGHT_FULL : data[6:0];
      REG_MAX_DELAY:   set_max   = data;
      REG_MIN_DELAY:   set_min   = data;
      REG_PULSE_TICKS: set_pulse = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic close_writes();
    cfg_write_en <= 1'b0;
  endtask

  // Offers one word, holds it through any stall and records the expected
  // result at the edge where it is taken. Called and returns at a falling edge
  // with the valid left high.
  task automatic send_word(input logic zc, input logic tk, input bit known,
                           input logic k_gate, input phase_t k_ph);
    dimmer_out_t pred;
    while ($urandom_range(0, 99) < gap_pct(1'b1)) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    zero_cross <= zc;
    tick       <= tk;
    do @(posedge clk); while (item_stall);
    pred = dimmer_step(zc, tk);
    if (known) begin
      pred.gate = k_gate;
      pred.ph   = k_ph;
    end
    gate_expect_q.push_back(pred);
    words_sent++;
    if (zc) crossings++;
    @(negedge clk);
  endtask

  task automatic stop_words();
    item_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (gate_expect_q.size() != 0) @(negedge clk);
  endtask

  // Result side: stalls at random, or for a long counted stretch on request.
  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_left    = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < gap_pct(1'b0));
    end
  end

  // Each word taken from the block is checked against the oldest expectation.
  always @(posedge clk) begin
    dimmer_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (gate_expect_q.size() == 0) begin
        note_mismatch($sformatf("result word with nothing expected (gate %0b phase %0d)",
                                gate_drive, phase));
      end else begin
        want = gate_expect_q.pop_front();
        if (gate_drive !== want.gate) begin
          note_mismatch($sformatf("word %0d gate_drive %0b, expected %0b",
                                  words_checked, gate_drive, want.gate));
        end
        if (phase !== want.ph) begin
          note_mismatch($sformatf("word %0d phase %0d, expected %0d",
                                  words_checked, phase, want.ph));
        end
        if (want.ph == PH_PULSE) firings++;
        words_checked++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] timeout after %0d cycles, %0d words still expected",
             $realtime, cycle_count, gate_expect_q.size());
    $display("triac_phase_angle_dimmer_core: mismatch");
    $finish;
  end

  initial begin
    logic [15:0] bright_w;
    logic        zc;
    logic        tk;
    int          pick;

    // Reset is held at the start and never asserted again.
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Register writes are only made once the pipeline is empty,
    // so that no word in flight sees a half-changed setting.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!in_writes) begin
          stop_words();
          wait_drained();
          in_writes = 1'b1;
        end
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (in_writes) begin
          close_writes();
          in_writes = 1'b0;
        end
        send_word(plan[i].zc, plan[i].tk, plan[i].known, plan[i].gate, plan[i].ph);
      end
    end

    // Random part. Each phase takes fresh settings, mostly short delays and
    // pulses so that whole firing cycles fit between crossings, and one phase
    // with full-range values. The idling pattern cycles through its four kinds.
    for (int p = 0; p < PHASES; p++) begin
      stop_words();
      wait_drained();
      idle_mode = idle_mode_t'(p % 4);

      pick = $urandom_range(0, 5);
      if (pick == 0) bright_w = 16'd0;
      else if (pick == 1) bright_w = 16'($urandom_range(0, 65535));
      else bright_w = 16'($urandom_range(1, 100));
      write_reg(REG_BRIGHTNESS, bright_w);
      if (p == 6) begin
        write_reg(REG_MAX_DELAY, 16'($urandom_range(0, 65535)));
        write_reg(REG_MIN_DELAY, 16'($urandom_range(0, 65535)));
        write_reg(REG_PULSE_TICKS, 16'($urandom_range(0, 65535)));
      end else begin
        write_reg(REG_MAX_DELAY, 16'($urandom_range(0, 40)));
        write_reg(REG_MIN_DELAY, 16'($urandom_range(0, 40)));
        write_reg(REG_PULSE_TICKS, 16'($urandom_range(0, 15)));
      end
      close_writes();

      // In one phase the result side holds off for a long stretch while words
      // keep coming, so the pipeline fills and the input is stalled.
      if (p == 5) hold_off_req = 1'b1;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        zc = ($urandom_range(0, 39) == 0);
        tk = ($urandom_range(0, 99) < 85);
        send_word(zc, tk, 1'b0, 1'b0, PH_IDLE);
      end
    end

    stop_words();
    wait_drained();
    // A further wait catches any stray result word after the last one.
    repeat (8) @(negedge clk);

    $display("Run covered %0d words (%0d zero crossings) and %0d register writes;",
             words_sent, crossings, cfg_writes);
    $display("%0d results checked, %0d of them with the gate pulse active, %0d cycles.",
             words_checked, firings, cycle_count);
    if (mismatches == 0) begin
      $display("triac_phase_angle_dimmer_core: match");
    end else begin
      $display("triac_phase_angle_dimmer_core: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tpd_pkg.sv
rtl/tpd_cfg.sv
rtl/tpd_ctrl.sv
rtl/triac_phase_angle_dimmer_core.sv
tb/tb.sv
